>>> src/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and fixed constants of the motion activity classifier.
// ----------------------------------------------------------------------------
package mac_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_WIN1,
        ST_WIN2,
        ST_WIN3,
        ST_VPRE,
        ST_VSUB,
        ST_DIV,
        ST_FIN
    } mac_state_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_OFFSET_X     = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z     = 3'd2;
    localparam logic [2:0] REG_STEP_THRESH  = 3'd3;
    localparam logic [2:0] REG_STEP_DEBOUNCE = 3'd4;
    localparam logic [2:0] REG_LIGHT_THRESH = 3'd5;
    localparam logic [2:0] REG_ACTIVE_THRESH = 3'd6;
    localparam logic [2:0] REG_SCRATCH_THRESH = 3'd7;

    localparam logic       CMD_SAMPLE = 1'b0;
    localparam logic       CMD_CLEAR  = 1'b1;

    localparam logic [13:0] ONE_G        = 14'd1024;
    localparam logic [13:0] ONE_HALF_G   = 14'd1536;
    localparam logic [25:0] VAR_REST     = 26'd10486;
    localparam logic [25:0] VAR_LIGHT    = 26'd104858;
    localparam logic [25:0] VAR_ACTIVE   = 26'd524288;
    localparam logic [14:0] MEAN_BIAS    = 15'd512;
    localparam logic [31:0] SLEEP_MS     = 32'd60000;
    localparam logic [31:0] MINUTE_MS    = 32'd60000;
    localparam logic [31:0] BURST_MIN_MS = 32'd500;
    localparam logic [31:0] BURST_MAX_MS = 32'd2000;
    localparam logic [31:0] BURST_CLR_MS = 32'd5000;
    localparam logic [15:0] BURST_SPIKES = 16'd5;

    localparam int QUOT_W = 28;   // bound on variance quotient width
    localparam int MAG_W  = 14;

endpackage

>>> src/motion_activity_classifier.sv
// ----------------------------------------------------------------------------
// motion_activity_classifier
// Pedometer and activity classifier on three-axis acceleration words.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   input   | s_valid / s_ready  | s_cmd, s_accel_x/y/z, s_now_ms
//   result  | m_valid / m_ready  | step count, level, flags, minutes, mag, var
//   config  | cfg_wr_en          | cfg_index, cfg_data
//
// A sample word runs from acceptance to its result through bit-serial
// squaring, a one-bit-per-cycle square root, the window and multiply update,
// the bit-serial divider that forms the variance, and a final step that loads
// the result. A clear word only runs the variance steps. The block works on
// one word at a time; s_ready is high in the idle state, so a new word is
// taken only once the last one has left its final step.
// A finished result waits in the output register, and the next word is taken
// meanwhile; only its final cycle stalls on m_ready.
// Reset is synchronous and active low; the history valid bits clear at once.
// ----------------------------------------------------------------------------
module motion_activity_classifier #(
    parameter int WINDOW = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic signed [13:0] s_accel_x,
    input  logic signed [13:0] s_accel_y,
    input  logic signed [13:0] s_accel_z,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_step_count,
    output logic [1:0]  m_activity_level,
    output logic        m_is_moving,
    output logic        m_is_sleeping,
    output logic        m_is_scratching,
    output logic [15:0] m_active_minutes,
    output logic [13:0] m_magnitude,
    output logic [25:0] m_variance
);
    import mac_pkg::*;

    localparam int LW    = $clog2(WINDOW);
    localparam int SUM_W = MAG_W + LW;
    localparam int SQ_W  = 2 * MAG_W + LW;
    localparam int DIV_W = 2 * MAG_W + 2 * LW;
    localparam int DEN_W = 2 * LW + 1;
    localparam int MT_W  = 15 + LW;
    localparam logic [DEN_W-1:0] DEN = DEN_W'(WINDOW * WINDOW);

    // Configuration registers.
    logic signed [13:0] off_x_reg, off_y_reg, off_z_reg;
    logic [13:0] step_thr_reg, light_thr_reg, active_thr_reg, scratch_thr_reg;
    logic [15:0] debounce_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg       <= '0;
            off_y_reg       <= '0;
            off_z_reg       <= '0;
            step_thr_reg    <= 14'd1331;
            debounce_reg    <= 16'd250;
            light_thr_reg   <= 14'd512;
            active_thr_reg  <= 14'd1024;
            scratch_thr_reg <= 14'd2560;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OFFSET_X:       off_x_reg       <= cfg_data[13:0];
                REG_OFFSET_Y:       off_y_reg       <= cfg_data[13:0];
                REG_OFFSET_Z:       off_z_reg       <= cfg_data[13:0];
                REG_STEP_THRESH:    step_thr_reg    <= cfg_data[13:0];
                REG_STEP_DEBOUNCE:  debounce_reg    <= cfg_data;
                REG_LIGHT_THRESH:   light_thr_reg   <= cfg_data[13:0];
                REG_ACTIVE_THRESH:  active_thr_reg  <= cfg_data[13:0];
                REG_SCRATCH_THRESH: scratch_thr_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Offset removal with saturation to signed 14 bits, then absolute value.
    function automatic logic [13:0] abs_diff(input logic signed [13:0] a,
                                             input logic signed [13:0] o);
        logic signed [14:0] d;
        logic signed [13:0] s;
        begin
            d = {a[13], a} - {o[13], o};
            if (d[14] != d[13]) s = d[14] ? 14'sh2000 : 14'sh1FFF;
            else                s = d[13:0];
            abs_diff = s[13] ? 14'(-s) : s;
        end
    endfunction

    mac_state_t state_reg, state_next;

    logic              cmd_reg;
    logic [31:0]       now_reg;
    logic [13:0]       ax_reg, ay_reg, az_reg;     // multiplicands
    logic [13:0]       bx_reg, by_reg, bz_reg;     // multiplier shift registers
    logic [27:0]       acc_reg;                    // sum of squares, then radicand
    logic [16:0]       rem_reg;
    logic [13:0]       root_reg;
    logic [4:0]        cnt_reg;
    logic [13:0]       mag_reg;
    logic [27:0]       prod_reg;
    logic [DIV_W-1:0]  sprod_reg;
    logic [DEN_W-1:0]  drem_reg;
    logic [QUOT_W-1:0] quot_reg;

    // Window state: history memory with per-entry valid bits.
    logic [13:0]       hist_mem [WINDOW];
    logic [WINDOW-1:0] hist_vld_reg;
    logic [13:0]       hist_rd_reg;
    logic [LW-1:0]     ptr_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sumsq_reg;

    // Tracker state.
    logic [31:0] steps_reg, last_step_reg, last_active_reg, minute_mark_reg;
    logic [31:0] burst_start_reg;
    logic [15:0] minutes_reg, spikes_reg;
    logic [13:0] prev_mag_reg;
    logic        seek_reg, in_burst_reg;
    logic [1:0]  level_reg;
    logic        moving_reg, sleeping_reg, scratch_reg;

    // Output register.
    logic        m_valid_reg;

    // The pointer always stays below the window size.
    always_ff @(posedge aclk) begin
        hist_rd_reg <= hist_mem[ptr_reg];
        if (state_reg == ST_WIN1) hist_mem[ptr_reg] <= mag_reg;
    end

    // Combinational step of each serial unit.
    logic [27:0]      sq_add;
    logic [16:0]      sqrt_t;
    logic [15:0]      sqrt_trial;
    logic [DEN_W:0]   div_t;
    logic [13:0]      old_mag;
    logic [DIV_W-1:0] wsq;
    logic [25:0]      var_sat;
    logic             fin_go;

    assign sq_add     = 28'(bx_reg[13] ? ax_reg : 14'd0) + 28'(by_reg[13] ? ay_reg : 14'd0)
                      + 28'(bz_reg[13] ? az_reg : 14'd0);
    assign sqrt_t     = {rem_reg[14:0], acc_reg[27:26]};
    assign sqrt_trial = {root_reg, 2'b01};
    assign div_t      = {drem_reg, quot_reg[QUOT_W-1]};
    assign old_mag    = hist_vld_reg[ptr_reg] ? hist_rd_reg : 14'd0;
    assign wsq        = DIV_W'(sumsq_reg) * DIV_W'(WINDOW);
    assign var_sat    = (quot_reg[QUOT_W-1:26] != '0) ? 26'h3FFFFFF : quot_reg[25:0];
    assign fin_go     = !m_valid_reg || m_ready;

    // Decisions of the final cycle.
    logic [31:0]     dt_step, dt_active, dt_minute, dt_burst;
    logic            rest, light_lvl, active_lvl, step_hit, spike;
    logic [MT_W-1:0] light_lim, active_lim, sum_ext;
    logic [1:0]      level_new;

    assign dt_step    = now_reg - last_step_reg;
    assign dt_active  = now_reg - last_active_reg;
    assign dt_minute  = now_reg - minute_mark_reg;
    assign dt_burst   = now_reg - burst_start_reg;
    assign sum_ext    = MT_W'(sum_reg);
    assign light_lim  = MT_W'(WINDOW) * MT_W'({1'b0, light_thr_reg} + MEAN_BIAS);
    assign active_lim = MT_W'(WINDOW) * MT_W'({1'b0, active_thr_reg} + MEAN_BIAS);
    assign rest       = var_sat < VAR_REST;
    assign light_lvl  = (var_sat < VAR_LIGHT) || (sum_ext < light_lim);
    assign active_lvl = (var_sat < VAR_ACTIVE) || (sum_ext < active_lim);
    assign level_new  = rest ? 2'd0 : light_lvl ? 2'd1 : active_lvl ? 2'd2 : 2'd3;
    assign spike      = mag_reg > scratch_thr_reg;
    assign step_hit   = !seek_reg && !(mag_reg < ONE_G && prev_mag_reg >= mag_reg)
                      && mag_reg > prev_mag_reg && prev_mag_reg < ONE_G;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = (s_cmd == CMD_CLEAR) ? ST_VPRE : ST_SQ;
            ST_SQ:   if (cnt_reg == 5'd0) state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == 5'd0) state_next = ST_WIN1;
            ST_WIN1: state_next = ST_WIN2;
            ST_WIN2: state_next = ST_WIN3;
            ST_WIN3: state_next = ST_VPRE;
            ST_VPRE: state_next = ST_VSUB;
            ST_VSUB: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd0) state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg <= s_cmd;
                now_reg <= s_now_ms;
                ax_reg  <= abs_diff(s_accel_x, off_x_reg);
                ay_reg  <= abs_diff(s_accel_y, off_y_reg);
                az_reg  <= abs_diff(s_accel_z, off_z_reg);
                bx_reg  <= abs_diff(s_accel_x, off_x_reg);
                by_reg  <= abs_diff(s_accel_y, off_y_reg);
                bz_reg  <= abs_diff(s_accel_z, off_z_reg);
                acc_reg <= '0;
                cnt_reg <= 5'd13;
            end
            ST_SQ: begin
                // MSB-first shift and add over all three axes at once.
                acc_reg <= {acc_reg[26:0], 1'b0} + sq_add;
                bx_reg  <= {bx_reg[12:0], 1'b0};
                by_reg  <= {by_reg[12:0], 1'b0};
                bz_reg  <= {bz_reg[12:0], 1'b0};
                if (cnt_reg == 5'd0) begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= 5'd13;
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            ST_SQRT: begin
                // Restoring square root, two radicand bits per cycle.
                acc_reg <= {acc_reg[25:0], 2'b00};
                if (sqrt_t >= 17'(sqrt_trial)) begin
                    rem_reg  <= sqrt_t - 17'(sqrt_trial);
                    root_reg <= {root_reg[12:0], 1'b1};
                end else begin
                    rem_reg  <= sqrt_t;
                    root_reg <= {root_reg[12:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    mag_reg <= (sqrt_t >= 17'(sqrt_trial)) ? {root_reg[12:0], 1'b1}
                                                         : {root_reg[12:0], 1'b0};
                end
            end
            ST_WIN1: prod_reg <= 28'(old_mag) * 28'(old_mag);
            ST_WIN2: prod_reg <= 28'(mag_reg) * 28'(mag_reg);
            ST_VPRE: sprod_reg <= DIV_W'(sum_reg) * DIV_W'(sum_reg);
            ST_VSUB: begin
                if (wsq > sprod_reg) begin
                    drem_reg <= DEN_W'((wsq - sprod_reg) >> QUOT_W);
                    quot_reg <= QUOT_W'(wsq - sprod_reg);
                end else begin
                    drem_reg <= '0;
                    quot_reg <= '0;
                end
                cnt_reg <= 5'(QUOT_W - 1);
            end
            ST_DIV: begin
                // Restoring division by the constant window size squared.
                if (div_t >= {1'b0, DEN}) begin
                    drem_reg <= DEN_W'(div_t - {1'b0, DEN});
                    quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    drem_reg <= DEN_W'(div_t);
                    quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            default: ;
        endcase
    end

    // Window and tracker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg    <= '0;
            ptr_reg         <= '0;
            sum_reg         <= '0;
            sumsq_reg       <= '0;
            steps_reg       <= '0;
            last_step_reg   <= '0;
            prev_mag_reg    <= ONE_G;
            seek_reg        <= 1'b1;
            last_active_reg <= '0;
            minute_mark_reg <= '0;
            minutes_reg     <= '0;
            level_reg       <= '0;
            moving_reg      <= 1'b0;
            sleeping_reg    <= 1'b0;
            scratch_reg     <= 1'b0;
            burst_start_reg <= '0;
            spikes_reg      <= '0;
            in_burst_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (state_reg == ST_FIN && fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_WIN1: begin
                    sum_reg <= sum_reg - SUM_W'(old_mag) + SUM_W'(mag_reg);
                    hist_vld_reg[ptr_reg] <= 1'b1;
                    ptr_reg <= (ptr_reg == LW'(WINDOW - 1)) ? '0 : ptr_reg + LW'(1);
                end
                ST_WIN2: sumsq_reg <= sumsq_reg - SQ_W'(prod_reg);
                ST_WIN3: sumsq_reg <= sumsq_reg + SQ_W'(prod_reg);
                ST_FIN: begin
                    if (fin_go) begin
                        if (cmd_reg == CMD_CLEAR) begin
                            steps_reg <= '0;
                        end else begin
                            // Peak and trough search, frozen during debounce.
                            if (dt_step >= 32'(debounce_reg)) begin
                                if (seek_reg) begin
                                    if (!(mag_reg > step_thr_reg && prev_mag_reg <= mag_reg)
                                        && mag_reg < prev_mag_reg
                                        && prev_mag_reg > step_thr_reg) begin
                                        seek_reg <= 1'b0;
                                    end
                                end else if (step_hit) begin
                                    if (steps_reg != 32'hFFFFFFFF) steps_reg <= steps_reg + 32'd1;
                                    last_step_reg <= now_reg;
                                    seek_reg      <= 1'b1;
                                end
                            end
                            prev_mag_reg <= mag_reg;

                            level_reg  <= level_new;
                            moving_reg <= !rest;
                            if (rest) begin
                                sleeping_reg <= dt_active > SLEEP_MS;
                            end else begin
                                sleeping_reg    <= 1'b0;
                                last_active_reg <= now_reg;
                            end
                            if (!rest && dt_minute >= MINUTE_MS) begin
                                if (minutes_reg != 16'hFFFF) minutes_reg <= minutes_reg + 16'd1;
                                minute_mark_reg <= now_reg;
                            end

                            // Scratch bursts: spikes open or extend a burst; a quiet
                            // sample decides the flag and closes the burst unless it sets the flag.
                            if (spike) begin
                                if (!in_burst_reg) begin
                                    burst_start_reg <= now_reg;
                                    in_burst_reg    <= 1'b1;
                                    spikes_reg      <= 16'd1;
                                end else if (spikes_reg != 16'hFFFF) begin
                                    spikes_reg <= spikes_reg + 16'd1;
                                end
                            end else if (in_burst_reg && mag_reg < ONE_HALF_G) begin
                                if (dt_burst > BURST_MIN_MS && dt_burst < BURST_MAX_MS
                                    && spikes_reg > BURST_SPIKES) begin
                                    scratch_reg <= 1'b1;
                                end else begin
                                    in_burst_reg <= 1'b0;
                                    spikes_reg   <= '0;
                                    if (dt_burst > BURST_CLR_MS) scratch_reg <= 1'b0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result payload, loaded with the valid flag.
    logic [25:0] var_out_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && fin_go) var_out_reg <= var_sat;
    end

    assign m_valid          = m_valid_reg;
    assign m_step_count     = steps_reg;
    assign m_activity_level = level_reg;
    assign m_is_moving      = moving_reg;
    assign m_is_sleeping    = sleeping_reg;
    assign m_is_scratching  = scratch_reg;
    assign m_active_minutes = minutes_reg;
    assign m_magnitude      = prev_mag_reg;
    assign m_variance       = var_out_reg;

endmodule
